@@ rtl/sh_order2_rotation_macros.svh @@
// Assertion macros shared by the order-2 SH rotation RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef SH_ORDER2_ROTATION_MACROS_SVH
`define SH_ORDER2_ROTATION_MACROS_SVH

`define SHR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("shr assertion failed");

`define SHR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("shr assertion failed");

`define SHR_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("shr reset assertion failed");

`endif

@@ rtl/shr_pkg.sv @@
// Package for the order-2 SH rotation: widths, constants, types and rounding helpers.
// Used by shr_lane, shr_merge and sh_order2_rotation; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package shr_pkg;

   localparam int CW  = 16;
   localparam int F   = 14;
   localparam int EW  = F + 2;
   localparam int CSW = EW + 1;
   localparam int SW  = 20;
   localparam int QW  = 21;
   localparam int PW  = 28;
   localparam int DW  = 31;
   localparam int BW  = 20;
   localparam int NLANE = 5;
   localparam int NCOEF = 9;

   localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775393;
   localparam logic signed [QW-1:0] K1 = -QW'(((2**F) + 1) / 3);
   localparam logic signed [QW-1:0] K2 = -QW'(((2**(F + 1)) + 1) / 3);
   localparam logic signed [63:0] CMAX = 64'(2**(CW - 1) - 1);
   localparam logic signed [63:0] CMIN = -64'(2**(CW - 1));

   typedef logic signed [CW-1:0] coef_type;

   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
      logic en5;
   } shr_ctl_type;

   typedef struct packed {
      logic signed [CSW-1:0] a;
      logic signed [CSW-1:0] b;
      logic signed [CSW-1:0] c;
      logic signed [QW-1:0]  k;
   } lane_col_type;

   typedef struct packed {
      logic signed [PW-1:0] t0;
      logic signed [PW-1:0] t1;
      logic signed [PW-1:0] t2;
      logic signed [PW-1:0] t3;
      logic signed [PW-1:0] t4;
   } lane_prod_type;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] p,
                                              input int unsigned s);
      logic neg;
      logic [63:0] mag;
      logic [63:0] r;
      neg = p[63];
      mag = neg ? 64'(-p) : 64'(p);
      r = (mag + (64'd1 << (s - 1))) >> s;
      rnd = neg ? -$signed(r) : $signed(r);
   endfunction

   function automatic coef_type sat(input logic signed [63:0] v);
      if (v > CMAX) begin
         sat = coef_type'(CMAX);
      end else if (v < CMIN) begin
         sat = coef_type'(CMIN);
      end else begin
         sat = v[CW-1:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ rtl/sh_order2_rotation.sv @@
// Top level of the order-2 SH rotation: register port, input stage, band 1, lanes, merge.
// Depends on shr_pkg, shr_lane, shr_merge and sh_order2_rotation_macros.svh.
//
//   channel | ports            | direction | handshake
//   input   | req_coef_in0..8  | in        | req_valid / req_stall
//   result  | rsp_coef_out0..8 | out       | rsp_valid / rsp_stall
//   config  | csr_p*           | in/out    | APB write, pready always high
//
// One item per cycle is sustained while rsp_stall is low; each item passes through five register
// stages in order: input, lane quadratic, lane product,
// lane sum, final constant and saturation. Stages advance independently, so bubbles close up.
// Reset clears the valid bits and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none
`include "sh_order2_rotation_macros.svh"
module sh_order2_rotation (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  shr_pkg::coef_type       req_coef_in0,
   input  shr_pkg::coef_type       req_coef_in1,
   input  shr_pkg::coef_type       req_coef_in2,
   input  shr_pkg::coef_type       req_coef_in3,
   input  shr_pkg::coef_type       req_coef_in4,
   input  shr_pkg::coef_type       req_coef_in5,
   input  shr_pkg::coef_type       req_coef_in6,
   input  shr_pkg::coef_type       req_coef_in7,
   input  shr_pkg::coef_type       req_coef_in8,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output shr_pkg::coef_type       rsp_coef_out0,
   output shr_pkg::coef_type       rsp_coef_out1,
   output shr_pkg::coef_type       rsp_coef_out2,
   output shr_pkg::coef_type       rsp_coef_out3,
   output shr_pkg::coef_type       rsp_coef_out4,
   output shr_pkg::coef_type       rsp_coef_out5,
   output shr_pkg::coef_type       rsp_coef_out6,
   output shr_pkg::coef_type       rsp_coef_out7,
   output shr_pkg::coef_type       rsp_coef_out8,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [4:0]              csr_paddr,
   input  logic [63:0]             csr_pwdata,
   output logic [63:0]             csr_prdata,
   output logic                    csr_pready
);
   import shr_pkg::*;

   localparam logic [1:0] REG_ROW0 = 2'd0;
   localparam logic [1:0] REG_ROW1 = 2'd1;
   localparam logic [1:0] REG_ROW2 = 2'd2;
   localparam int RW = 3 * EW;

   logic [RW-1:0] row0_ff, row1_ff, row2_ff;
   logic [1:0] csr_index;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1;
   shr_ctl_type ctl;
   coef_type x_ff [NCOEF];
   logic signed [EW-1:0] r [3][3];
   lane_col_type col [NLANE];
   logic signed [SW-1:0] s [NLANE];
   logic signed [CW+31:0] y2m;
   logic signed [2*EW-1:0] bp [3][3];
   logic signed [BW-1:0] b1_in [3];
   logic signed [BW-1:0] b1_ff [3];
   coef_type x0_2_ff;
   coef_type lo_ff [4];
   lane_prod_type prod [NLANE];
   coef_type coef_out [NCOEF];

   assign csr_index = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_ROW0: csr_prdata = 64'(row0_ff);
         REG_ROW1: csr_prdata = 64'(row1_ff);
         REG_ROW2: csr_prdata = 64'(row2_ff);
         default:  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= RW'(1) << F;
         row1_ff <= RW'(1) << (F + EW);
         row2_ff <= RW'(1) << (F + 2 * EW);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_index)
            REG_ROW0: row0_ff <= csr_pwdata[RW-1:0];
            REG_ROW1: row1_ff <= csr_pwdata[RW-1:0];
            REG_ROW2: row2_ff <= csr_pwdata[RW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         r[0][c] = row0_ff[c*EW +: EW];
         r[1][c] = row1_ff[c*EW +: EW];
         r[2][c] = row2_ff[c*EW +: EW];
      end
   end

   function automatic lane_col_type pick(input int i, input logic signed [EW-1:0] r0,
                                         input logic signed [EW-1:0] r1,
                                         input logic signed [EW-1:0] r2,
                                         input logic signed [QW-1:0] k);
      lane_col_type v;
      logic signed [CSW-1:0] e0, e1, e2, t;
      e0 = CSW'(r0);
      e1 = CSW'(r1);
      e2 = CSW'(r2);
      case (i)
         0:       t = e0;
         1:       t = e2;
         2:       t = e0 + e1;
         3:       t = e0 + e2;
         default: t = e1 + e2;
      endcase
      v.a = '0;
      v.b = '0;
      v.c = t;
      v.k = k;
      pick = v;
   endfunction

   always_comb begin
      lane_col_type ta, tb, tc;
      for (int i = 0; i < NLANE; i++) begin
         ta = pick(i, r[0][0], r[0][1], r[0][2], K1);
         tb = pick(i, r[1][0], r[1][1], r[1][2], K1);
         tc = pick(i, r[2][0], r[2][1], r[2][2], (i < 2) ? K1 : K2);
         col[i].a = ta.c;
         col[i].b = tb.c;
         col[i].c = tc.c;
         col[i].k = tc.k;
      end
   end

   assign y2m = x_ff[6] * SQRT3_Q30;

   always_comb begin
      s[0] = SW'(x_ff[7]) + (SW'(x_ff[8]) <<< 1) - SW'(x_ff[5]);
      s[1] = SW'(x_ff[4]) + SW'(rnd(64'(y2m), 30)) + SW'(x_ff[7]) + SW'(x_ff[8]);
      s[2] = SW'(x_ff[4]);
      s[3] = -SW'(x_ff[7]);
      s[4] = -SW'(x_ff[5]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         bp[i][0] = r[i][1] * x_ff[1];
         bp[i][1] = r[i][2] * x_ff[2];
         bp[i][2] = r[i][0] * x_ff[3];
      end
      b1_in[0] = BW'(rnd(64'(bp[1][0]), F) - rnd(64'(bp[1][1]), F)
                     + rnd(64'(bp[1][2]), F));
      b1_in[1] = BW'(-rnd(64'(bp[2][0]), F) + rnd(64'(bp[2][1]), F)
                     - rnd(64'(bp[2][2]), F));
      b1_in[2] = BW'(rnd(64'(bp[0][0]), F) - rnd(64'(bp[0][1]), F)
                     + rnd(64'(bp[0][2]), F));
   end

   assign ctl.en5 = !v5_ff || !rsp_stall;
   assign ctl.en4 = !v4_ff || ctl.en5;
   assign ctl.en3 = !v3_ff || ctl.en4;
   assign ctl.en2 = !v2_ff || ctl.en3;
   assign en1 = !v1_ff || ctl.en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (ctl.en2) v2_ff <= v1_ff;
         if (ctl.en3) v3_ff <= v2_ff;
         if (ctl.en4) v4_ff <= v3_ff;
         if (ctl.en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         x_ff[0] <= req_coef_in0;
         x_ff[1] <= req_coef_in1;
         x_ff[2] <= req_coef_in2;
         x_ff[3] <= req_coef_in3;
         x_ff[4] <= req_coef_in4;
         x_ff[5] <= req_coef_in5;
         x_ff[6] <= req_coef_in6;
         x_ff[7] <= req_coef_in7;
         x_ff[8] <= req_coef_in8;
      end
      if (ctl.en2) begin
         b1_ff   <= b1_in;
         x0_2_ff <= x_ff[0];
      end
      if (ctl.en3) begin
         lo_ff[0] <= x0_2_ff;
         for (int i = 0; i < 3; i++) begin
            lo_ff[i + 1] <= sat(64'(b1_ff[i]));
         end
      end
   end

   for (genvar g = 0; g < NLANE; g++) begin : g_lane
      shr_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .col   (col[g]),
         .s_in  (s[g]),
         .prod  (prod[g])
      );
   end

   shr_merge u_merge (
      .clock    (clock),
      .ctl      (ctl),
      .prod     (prod),
      .lo_in    (lo_ff),
      .coef_out (coef_out)
   );

   assign rsp_valid     = v5_ff;
   assign rsp_coef_out0 = coef_out[0];
   assign rsp_coef_out1 = coef_out[1];
   assign rsp_coef_out2 = coef_out[2];
   assign rsp_coef_out3 = coef_out[3];
   assign rsp_coef_out4 = coef_out[4];
   assign rsp_coef_out5 = coef_out[5];
   assign rsp_coef_out6 = coef_out[6];
   assign rsp_coef_out7 = coef_out[7];
   assign rsp_coef_out8 = coef_out[8];

   `SHR_ASSERT_NOW(a_stall_full, req_stall, v1_ff && v2_ff && v3_ff && v4_ff && v5_ff)
   `SHR_ASSERT_NEXT(a_accept_fills, req_valid && !req_stall, v1_ff)
   `SHR_ASSERT_RESET(a_reset_empty, !v1_ff && !v3_ff && !v5_ff)

endmodule
`default_nettype wire

@@ rtl/shr_lane.sv @@
// One band-2 lane: quadratic column products, then the product with its pre-sum.
// Depends on shr_pkg; stages two and three of the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module shr_lane (
   input  logic                        clock,
   input  shr_pkg::shr_ctl_type        ctl,
   input  shr_pkg::lane_col_type       col,
   input  logic signed [shr_pkg::SW-1:0] s_in,
   output shr_pkg::lane_prod_type      prod
);
   import shr_pkg::*;

   logic signed [2*CSW-1:0] pab, pbc, pcc, pac, paa, pbb;
   logic signed [QW-1:0] q0_in, q1_in, q2_in, q3_in, q4_in;
   logic signed [QW-1:0] q0_ff, q1_ff, q2_ff, q3_ff, q4_ff;
   logic signed [SW-1:0] s_ff;
   logic signed [SW+QW-1:0] m0, m1, m2, m3, m4;
   lane_prod_type prod_in, prod_ff;

   assign pab = $signed(col.a) * $signed(col.b);
   assign pbc = $signed(col.b) * $signed(col.c);
   assign pcc = $signed(col.c) * $signed(col.c);
   assign pac = $signed(col.a) * $signed(col.c);
   assign paa = $signed(col.a) * $signed(col.a);
   assign pbb = $signed(col.b) * $signed(col.b);

   assign q0_in = QW'(rnd(64'(pab), F));
   assign q1_in = QW'(rnd(64'(pbc), F));
   assign q2_in = QW'(rnd(64'(pcc), F) + 64'($signed(col.k)));
   assign q3_in = QW'(rnd(64'(pac), F));
   assign q4_in = QW'(rnd(64'(paa), F) - rnd(64'(pbb), F));

   assign m0 = s_ff * q0_ff;
   assign m1 = s_ff * q1_ff;
   assign m2 = s_ff * q2_ff;
   assign m3 = s_ff * q3_ff;
   assign m4 = s_ff * q4_ff;

   always_comb begin
      prod_in.t0 = PW'(rnd(64'(m0), F));
      prod_in.t1 = PW'(rnd(64'(m1), F));
      prod_in.t2 = PW'(rnd(64'(m2), F));
      prod_in.t3 = PW'(rnd(64'(m3), F));
      prod_in.t4 = PW'(rnd(64'(m4), F));
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         q0_ff <= q0_in;
         q1_ff <= q1_in;
         q2_ff <= q2_in;
         q3_ff <= q3_in;
         q4_ff <= q4_in;
         s_ff  <= s_in;
      end
      if (ctl.en3) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

@@ rtl/shr_merge.sv @@
// Merge stage: sums the lane products, applies the final constants and saturates.
// Depends on shr_pkg; stages four and five, whose registers drive the result item.
`timescale 1ns / 1ps
`default_nettype none
module shr_merge (
   input  logic                   clock,
   input  shr_pkg::shr_ctl_type   ctl,
   input  shr_pkg::lane_prod_type prod [shr_pkg::NLANE],
   input  shr_pkg::coef_type      lo_in [4],
   output shr_pkg::coef_type      coef_out [shr_pkg::NCOEF]
);
   import shr_pkg::*;

   logic signed [DW-1:0] d0_in, d1_in, d2_in, d3_in, d4_in;
   logic signed [DW-1:0] d0_ff, d1_ff, d2_ff, d3_ff, d4_ff;
   coef_type lo_ff [4];
   coef_type out_in [NCOEF];
   coef_type out_ff [NCOEF];
   logic signed [DW+31:0] d2m;

   always_comb begin
      d0_in = '0;
      d1_in = '0;
      d2_in = '0;
      d3_in = '0;
      d4_in = '0;
      for (int i = 0; i < NLANE; i++) begin
         d0_in = d0_in + DW'(prod[i].t0);
         d1_in = d1_in + DW'(prod[i].t1);
         d2_in = d2_in + DW'(prod[i].t2);
         d3_in = d3_in + DW'(prod[i].t3);
         d4_in = d4_in + DW'(prod[i].t4);
      end
   end

   assign d2m = d2_ff * SQRT3_Q30;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         out_in[i] = lo_ff[i];
      end
      out_in[4] = sat(64'(d0_ff));
      out_in[5] = sat(-64'(d1_ff));
      out_in[6] = sat(rnd(64'(d2m), 31));
      out_in[7] = sat(-64'(d3_ff));
      out_in[8] = sat(rnd(64'(d4_ff), 1));
   end

   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         d0_ff <= d0_in;
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         d3_ff <= d3_in;
         d4_ff <= d4_in;
         lo_ff <= lo_in;
      end
      if (ctl.en5) begin
         out_ff <= out_in;
      end
   end

   assign coef_out = out_ff;

endmodule
`default_nettype wire
